@@ rtl/tli_pkg.sv @@
// tli_pkg: shared widths, status codes and the front-end result struct
// for the two-line intersection pipeline. No dependencies.
package tli_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int QW     = 32;               // quotient / output width
	localparam int DIFF_W = COORD_BITS + 1;   // point difference
	localparam int PROD_W = 2 * DIFF_W;       // one product
	localparam int NUM_W  = PROD_W + 1;       // cross product, signed
	localparam int MAG_W  = NUM_W;            // magnitude of a cross product

	localparam int FRONT_LAT = 4;
	localparam int DIV_LAT   = QW + 2;
	localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

	localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_INTERSECT  = 2'd0,
		ST_DEGENERATE = 2'd1,
		ST_PARALLEL   = 2'd2,
		ST_COLLINEAR  = 2'd3
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic signed [NUM_W-1:0]  num_t;
		logic signed [NUM_W-1:0]  num_u;
		logic signed [NUM_W-1:0]  den;
	} front_t;

endpackage

@@ rtl/tli_front.sv @@
// tli_front: differences, products, cross products and classification,
// four register stages. Depends on tli_pkg.
module tli_front import tli_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] dx,
	input  logic signed [COORD_BITS-1:0] dy,
	output front_t                       res
);

	// stage 1: difference vectors
	logic signed [DIFF_W-1:0] vbx_s1, vby_s1, vdx_s1, vdy_s1;
	logic signed [DIFF_W-1:0] vcx_s1, vcy_s1, adx_s1, ady_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			vbx_s1 <= DIFF_W'(bx)       - DIFF_W'(ax);
			vby_s1 <= DIFF_W'(by_coord) - DIFF_W'(ay);
			vdx_s1 <= DIFF_W'(dx)       - DIFF_W'(cx);
			vdy_s1 <= DIFF_W'(dy)       - DIFF_W'(cy);
			vcx_s1 <= DIFF_W'(cx)       - DIFF_W'(ax);
			vcy_s1 <= DIFF_W'(cy)       - DIFF_W'(ay);
			adx_s1 <= DIFF_W'(dx)       - DIFF_W'(ax);
			ady_s1 <= DIFF_W'(dy)       - DIFF_W'(ay);
		end
	end

	// stage 2: six products
	logic signed [PROD_W-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [DIFF_W-1:0] vbx_s2, vby_s2, vcx_s2, vcy_s2, adx_s2, ady_s2;
	logic                     degen_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2    <= PROD_W'(vbx_s1) * PROD_W'(vdy_s1);
			p2_s2    <= PROD_W'(vby_s1) * PROD_W'(vdx_s1);
			p3_s2    <= PROD_W'(vcx_s1) * PROD_W'(vdy_s1);
			p4_s2    <= PROD_W'(vcy_s1) * PROD_W'(vdx_s1);
			p5_s2    <= PROD_W'(vcx_s1) * PROD_W'(vby_s1);
			p6_s2    <= PROD_W'(vcy_s1) * PROD_W'(vbx_s1);
			degen_s2 <= (vbx_s1 == '0 && vby_s1 == '0) || (vdx_s1 == '0 && vdy_s1 == '0);
			vbx_s2   <= vbx_s1;
			vby_s2   <= vby_s1;
			vcx_s2   <= vcx_s1;
			vcy_s2   <= vcy_s1;
			adx_s2   <= adx_s1;
			ady_s2   <= ady_s1;
		end
	end

	// stage 3: cross products
	logic signed [NUM_W-1:0]  den_s3, nt_s3, nu_s3;
	logic signed [DIFF_W-1:0] vbx_s3, vby_s3, vcx_s3, vcy_s3, adx_s3, ady_s3;
	logic                     degen_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3   <= NUM_W'(p1_s2) - NUM_W'(p2_s2);
			nt_s3    <= NUM_W'(p3_s2) - NUM_W'(p4_s2);
			nu_s3    <= NUM_W'(p5_s2) - NUM_W'(p6_s2);
			degen_s3 <= degen_s2;
			vbx_s3   <= vbx_s2;
			vby_s3   <= vby_s2;
			vcx_s3   <= vcx_s2;
			vcy_s3   <= vcy_s2;
			adx_s3   <= adx_s2;
			ady_s3   <= ady_s2;
		end
	end

	// stage 4: classify and pick divider operands; no-divide cases get 0/1
	front_t nxt;

	always_comb begin
		nxt.status = ST_INTERSECT;
		nxt.num_t  = nt_s3;
		nxt.num_u  = nu_s3;
		nxt.den    = den_s3;
		if (degen_s3) begin
			nxt.status = ST_DEGENERATE;
			nxt.num_t  = '0;
			nxt.num_u  = '0;
			nxt.den    = NUM_W'(1);
		end else if (den_s3 == '0) begin
			if (nt_s3 == '0) begin
				nxt.status = ST_COLLINEAR;
				if (vby_s3 != '0) begin
					nxt.num_t = NUM_W'(vcy_s3);
					nxt.num_u = NUM_W'(ady_s3);
					nxt.den   = NUM_W'(vby_s3);
				end else begin
					nxt.num_t = NUM_W'(vcx_s3);
					nxt.num_u = NUM_W'(adx_s3);
					nxt.den   = NUM_W'(vbx_s3);
				end
			end else begin
				nxt.status = ST_PARALLEL;
				nxt.num_t  = '0;
				nxt.num_u  = '0;
				nxt.den    = NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= nxt;
		end
	end

endmodule

@@ rtl/tli_div.sv @@
// tli_div: pipelined signed fixed-point divider, one quotient bit per
// stage, with saturation. Depends on tli_pkg.
module tli_div import tli_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [NUM_W-1:0] den,
	output logic [QW-1:0]           quo,
	output logic                    ovf
);

	localparam int X_W = MAG_W + QW;

	logic [MAG_W-1:0] un, ud;
	logic [X_W-1:0]   nx;

	always_comb begin
		un = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
		ud = den[NUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
		nx = X_W'(un) << FRAC_BITS;
	end

	logic [MAG_W-1:0] r_s   [0:QW];
	logic [QW-1:0]    lo_s  [0:QW];
	logic [QW-1:0]    q_s   [0:QW];
	logic [MAG_W-1:0] ud_s  [0:QW];
	logic             neg_s [0:QW];
	logic             big_s [0:QW];

	// entry stage: magnitudes and the quotient >= 2^QW check
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= nx[X_W-1:QW];
			lo_s[0]  <= nx[QW-1:0];
			q_s[0]   <= '0;
			ud_s[0]  <= ud;
			neg_s[0] <= num[NUM_W-1] ^ den[NUM_W-1];
			big_s[0] <= nx >= {ud, {QW{1'b0}}};
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [MAG_W:0]   r2;
		logic [MAG_W:0]   diff;
		logic             ge;

		always_comb begin
			r2   = {r_s[k], lo_s[k][QW-1]};
			diff = r2 - {1'b0, ud_s[k]};
			ge   = r2 >= {1'b0, ud_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]   <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
				lo_s[k+1]  <= {lo_s[k][QW-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				ud_s[k+1]  <= ud_s[k];
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
			end
		end
	end

	// exit stage: sign and saturation
	logic [QW-1:0] qf;
	logic          sat;

	always_comb begin
		qf  = q_s[QW];
		sat = big_s[QW] || (neg_s[QW] ? (qf > Q_MIN) : qf[QW-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf <= sat;
			if (sat) begin
				quo <= neg_s[QW] ? Q_MIN : Q_MAX;
			end else begin
				quo <= neg_s[QW] ? (QW'(0) - qf) : qf;
			end
		end
	end

endmodule

@@ rtl/two_line_intersection_params.sv @@
// two_line_intersection_params: parametric intersection of lines A-B and C-D.
// Depends on tli_pkg, tli_front, tli_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries the eight signed point
//   coordinates of one line pair per transfer. Output channel
//   (out_valid / out_stall) carries status, t_param, u_param (signed
//   Q16.16) and overflow, one result per input transfer, in order.
// Throughput: one transfer per cycle, sustained, while out_stall is low.
// Stages: 38 register stages in all, four front stages (differences,
//   products, cross products, classification) and 34 divider stages
//   (operand setup, 32 restoring quotient bit steps, sign and
//   saturation). Two dividers run side by side for t and u.
// Stall: the whole pipeline holds when a result is shown and out_stall
//   is high; in_stall is raised in that cycle so nothing is lost. Bubbles
//   travel as cleared valid bits.
// Reset: arst_n clears all valid bits at once; data registers are not
//   reset. The first transfer may follow right after reset release.
module two_line_intersection_params import tli_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] dx,
	input  logic signed [COORD_BITS-1:0] dy,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic signed [QW-1:0]         t_param,
	output logic signed [QW-1:0]         u_param,
	output logic                         overflow
);

	logic   adv;      // pipeline advances this cycle
	front_t front;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid bits, one per stage
	logic vld_s [0:TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < TOTAL_LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	assign out_valid = vld_s[TOTAL_LAT-1];

	tli_front u_front (
		.clk      (clk),
		.en       (adv),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by_coord (by_coord),
		.cx       (cx),
		.cy       (cy),
		.dx       (dx),
		.dy       (dy),
		.res      (front)
	);

	// status rides alongside the dividers
	status_t st_s [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= front.status;
			for (int i = 1; i < DIV_LAT; i++) st_s[i] <= st_s[i-1];
		end
	end

	logic [QW-1:0] t_quo, u_quo;
	logic          t_ovf, u_ovf;

	tli_div u_div_t (
		.clk (clk),
		.en  (adv),
		.num (front.num_t),
		.den (front.den),
		.quo (t_quo),
		.ovf (t_ovf)
	);

	tli_div u_div_u (
		.clk (clk),
		.en  (adv),
		.num (front.num_u),
		.den (front.den),
		.quo (u_quo),
		.ovf (u_ovf)
	);

	assign status   = st_s[DIV_LAT-1];
	assign t_param  = t_quo;
	assign u_param  = u_quo;
	assign overflow = t_ovf || u_ovf;

	// no-divide cases come out as zero with no saturation
	a_zero_cases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DEGENERATE || status == ST_PARALLEL)
		|-> t_param == '0 && u_param == '0 && !overflow)
		else $error("degenerate/parallel result not zero");

	// overflow only on dividing cases, and then a value is at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow
		|-> (status == ST_INTERSECT || status == ST_COLLINEAR)
		 && (t_param == Q_MAX || t_param == Q_MIN || u_param == Q_MAX || u_param == Q_MIN))
		else $error("overflow without saturated value");

	// a held result keeps its t_param and status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(t_param) && $stable(status))
		else $error("stalled result changed");

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for two_line_intersection_params. Depends on
// tli_pkg and the RTL. Directed table followed by a random mix of line pairs,
// each checked against a typed result or an in-bench fixed-point predictor.
`timescale 1ns / 1ps

module testbench;
	import tli_pkg::*;

	localparam int N_RANDOM  = 1630;
	localparam int WD_LIMIT  = 3000;  // idle cycles before giving up
	localparam int LONG_HOLD = 400;   // receiver hold-off, cycles

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t ax, ay, bx, by, cx, cy, dx, dy;
	} pair_t;

	typedef struct {
		status_t          st;
		logic [QW-1:0]    t, u;
		logic             ovf;
	} isect_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t ax = '0, ay = '0, bx = '0, by_coord = '0;
	coord_t cx = '0, cy = '0, dx = '0, dy = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic [1:0]           status;
	logic signed [QW-1:0] t_param, u_param;
	logic                 overflow;

	always #2 clk = ~clk;

	two_line_intersection_params uut (.*);

	// expectations in transfer order
	isect_t isect_q[$];
	isect_t cur_isect;   // expectation for the payload on the input now
	int     n_in, n_out, n_err, idle_cycles;
	int     st_count[4];
	bit     sending_done, quiet, hold_req;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// n/d as signed Q.FRAC_BITS, truncated toward zero, saturated
	function automatic logic [QW-1:0] q_divide(longint n, longint d, ref logic ovf);
		bit                neg;
		longint unsigned   un, ud, q, r, m;
		neg = (n < 0) != (d < 0);
		un  = n < 0 ? -n : n;
		ud  = d < 0 ? -d : d;
		if (ud == 0) return '0;
		q = un / ud;
		r = un % ud;
		if (q > (64'd1 << (31 - FRAC_BITS))) begin
			ovf = 1'b1;
			return neg ? Q_MIN : Q_MAX;
		end
		m = q << FRAC_BITS;
		for (int i = FRAC_BITS - 1; i >= 0; i--) begin
			r = r << 1;
			if (r >= ud) begin
				r -= ud;
				m |= 64'd1 << i;
			end
		end
		if (neg) begin
			if (m > 64'h8000_0000) begin
				ovf = 1'b1;
				return Q_MIN;
			end
			return QW'(-m);
		end
		if (m > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		return QW'(m);
	endfunction

	function automatic isect_t predict_isect(pair_t p);
		isect_t r;
		longint vbx, vby, vdx, vdy, vcx, vcy, den;
		logic   ovf;
		vbx = longint'(p.bx) - p.ax;  vby = longint'(p.by) - p.ay;
		vdx = longint'(p.dx) - p.cx;  vdy = longint'(p.dy) - p.cy;
		vcx = longint'(p.cx) - p.ax;  vcy = longint'(p.cy) - p.ay;
		ovf = 1'b0;
		r.t = '0;
		r.u = '0;
		if ((vbx == 0 && vby == 0) || (vdx == 0 && vdy == 0)) begin
			r.st = ST_DEGENERATE;
		end else if (vdx * vby - vdy * vbx == 0) begin
			if (vdx * vcy - vdy * vcx == 0) begin
				r.st = ST_COLLINEAR;
				// project on y unless AB is horizontal
				if (vby != 0) begin
					r.t = q_divide(vcy, vby, ovf);
					r.u = q_divide(longint'(p.dy) - p.ay, vby, ovf);
				end else begin
					r.t = q_divide(vcx, vbx, ovf);
					r.u = q_divide(longint'(p.dx) - p.ax, vbx, ovf);
				end
			end else begin
				r.st = ST_PARALLEL;
			end
		end else begin
			r.st = ST_INTERSECT;
			den  = vbx * vdy - vby * vdx;
			r.t  = q_divide(vcx * vdy - vcy * vdx, den, ovf);
			r.u  = q_divide(vcx * vby - vcy * vbx, den, ovf);
		end
		r.ovf = ovf;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------

	task automatic offer_pair(pair_t p, bit typed, isect_t want);
		if (!quiet && $urandom_range(0, 99) < 26) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		{ax, ay, bx, by_coord} = {p.ax, p.ay, p.bx, p.by};
		{cx, cy, dx, dy}       = {p.cx, p.cy, p.dx, p.dy};
		cur_isect = typed ? want : predict_isect(p);
		in_valid  = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic coord_t rnd_coord(int lim);
		return coord_t'($urandom_range(0, 2 * lim) - lim);
	endfunction

	// well-formed shapes with random content, plus full-range noise
	function automatic pair_t random_pair();
		pair_t p;
		int    kind, k, m, vx, vy;
		kind = $urandom_range(0, 99);
		p.ax = rnd_coord(200);  p.ay = rnd_coord(200);
		vx = $urandom_range(0, 40) - 20;
		vy = $urandom_range(0, 40) - 20;
		if (kind < 35) begin
			p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom)};
		end else if (kind < 60) begin
			p.bx = rnd_coord(300);  p.by = rnd_coord(300);
			p.cx = rnd_coord(300);  p.cy = rnd_coord(300);
			p.dx = rnd_coord(300);  p.dy = rnd_coord(300);
		end else if (kind < 75) begin
			// parallel or collinear: D-C is a multiple of B-A
			k = $urandom_range(0, 6) - 3;
			m = $urandom_range(0, 10) - 5;
			p.bx = coord_t'(p.ax + vx);  p.by = coord_t'(p.ay + vy);
			p.cx = coord_t'(int'(p.ax) + int'($urandom_range(0, 20)) - 10);
			p.cy = coord_t'(int'(p.ay) + int'($urandom_range(0, 20)) - 10);
			p.dx = coord_t'(p.cx + k * vx);  p.dy = coord_t'(p.cy + k * vy);
		end else if (kind < 92) begin
			// collinear: C and D on line AB; sometimes a horizontal AB
			if ($urandom_range(0, 2) == 0) vy = 0;
			k = $urandom_range(0, 200) - 100;
			m = $urandom_range(0, 200) - 100;
			p.bx = coord_t'(p.ax + vx);  p.by = coord_t'(p.ay + vy);
			p.cx = coord_t'(p.ax + k * vx);  p.cy = coord_t'(p.ay + k * vy);
			p.dx = coord_t'(p.ax + m * vx);  p.dy = coord_t'(p.ay + m * vy);
		end else begin
			// degenerate: one of the two lines is a point
			p.bx = p.ax;  p.by = p.ay;
			p.cx = rnd_coord(32767);  p.cy = rnd_coord(32767);
			p.dx = rnd_coord(32767);  p.dy = rnd_coord(32767);
			if ($urandom_range(0, 1)) begin
				p.bx = coord_t'(p.ax + 1);
				p.dx = p.cx;  p.dy = p.cy;
			end
		end
		return p;
	endfunction

	// directed table: pair, whether the result is typed in, typed result
	typedef struct {
		pair_t  p;
		bit     typed;
		isect_t want;
	} drow_t;

	localparam coord_t CMAX = 16'sh7FFF;
	localparam coord_t CMIN = 16'sh8000;
	localparam isect_t NONE = '{ST_INTERSECT, '0, '0, 1'b0};

	drow_t dtable[] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{ST_DEGENERATE, '0, '0, 1'b0}},
		'{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1,
			'{ST_DEGENERATE, '0, '0, 1'b0}},
		'{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1,
			'{ST_DEGENERATE, '0, '0, 1'b0}},
		'{'{0, 0, 5, 5, 3, 3, 3, 3}, 1, '{ST_DEGENERATE, '0, '0, 1'b0}},
		'{'{0, 0, 4, 0, 0, 1, 4, 1}, 1, '{ST_PARALLEL, '0, '0, 1'b0}},
		'{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1,
			'{ST_INTERSECT, 32'h0000_8000, 32'h0000_8000, 1'b0}},
		'{'{0, 0, 0, 1, 0, CMAX, 0, CMIN}, 1,
			'{ST_COLLINEAR, 32'h7FFF_0000, 32'h8000_0000, 1'b0}},
		'{'{0, 0, 2, 0, 4, 0, 6, 0}, 1,
			'{ST_COLLINEAR, 32'h0002_0000, 32'h0003_0000, 1'b0}},
		'{'{0, 0, 2, 2, 0, 2, 2, 0}, 0, NONE},
		'{'{1, 1, 2, 2, 3, 3, 5, 5}, 0, NONE},
		'{'{CMAX, CMIN, CMIN, CMAX, 0, 0, 1, 0}, 0, NONE},
		'{'{0, 0, 1, 0, CMAX, CMIN, CMAX, CMAX}, 0, NONE},
		'{'{0, 0, 1, 1, CMIN, 0, 0, CMIN}, 0, NONE},
		'{'{CMIN, 0, CMAX, 1, 0, CMIN, 1, CMAX}, 0, NONE},
		'{'{0, 0, 0, CMAX, 5, 0, 5, CMIN}, 0, NONE},
		'{'{3, -7, -3, 7, 100, -100, -100, 100}, 0, NONE},
		'{'{0, 0, 7, 3, -1, -1, 6, 2}, 0, NONE},
		'{'{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX}, 0, NONE}
	};

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dtable[i])
			offer_pair(dtable[i].p, dtable[i].typed, dtable[i].want);
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 400 && i < 650);
			if (i == 900) hold_req = 1'b1;
			offer_pair(random_pair(), 1'b0, NONE);
		end
		in_valid     = 1'b0;
		sending_done = 1'b1;
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, a quiet stretch and one long hold-off
	// ---------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0 && n_out < 1000) hold_left = LONG_HOLD;
			if (hold_left > 0) begin
				hold_left--;
				hold_req  = 1'b0;
				out_stall = 1'b1;
			end else begin
				out_stall = !quiet && $urandom_range(0, 99) < 21;
			end
		end
	end

	// ---------------------------------------------------------------
	// Scoreboard: log each input transfer, check each output transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		isect_t want;
		if (in_valid && !in_stall) begin
			isect_q.push_back(cur_isect);
			st_count[cur_isect.st]++;
			n_in++;
		end
		if (out_valid && !out_stall) begin
			n_out++;
			if (isect_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("result %0d with no transfer pending", n_out);
			end else begin
				want = isect_q.pop_front();
				if (status !== want.st || t_param !== want.t || u_param !== want.u ||
						overflow !== want.ovf) begin
					n_err++;
					if (n_err <= 10)
						$display("result %0d: exp st=%0d t=%h u=%h ovf=%b, got st=%0d t=%h u=%h ovf=%b",
							n_out, want.st, want.t, want.u, want.ovf,
							status, t_param, u_param, overflow);
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("timeout: %0d results pending", isect_q.size());
			$display("** two_line_intersection_params: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (sending_done);
		while (isect_q.size() != 0) @(posedge clk);
		repeat (TOTAL_LAT + 20) @(posedge clk);
		if (isect_q.size() != 0) n_err++;
		$display("%0d line pairs in, %0d results out, %0d mismatches", n_in, n_out, n_err);
		$display("intersecting %0d, degenerate %0d, parallel %0d, collinear %0d",
			st_count[0], st_count[1], st_count[2], st_count[3]);
		if (n_err == 0)
			$display("** two_line_intersection_params: PASSED **");
		else
			$display("** two_line_intersection_params: FAILED **");
		$finish;
	end

endmodule
